// ===== rtl/spce_pkg.sv =====
package spce_pkg;

    localparam int VAL_W      = 16;
    localparam int PULSE_W    = 12;
    localparam int CHAN_W     = 4;
    localparam int CHAN_OUT_W = 3;
    localparam int DUTY_W     = 13;
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register index on the APB port (paddr bit 2).
    localparam logic REG_MIRROR_RIGHT = 1'b0;

    localparam logic [PULSE_W-1:0] PULSE_MIN    = 12'd500;
    localparam logic [PULSE_W-1:0] PULSE_CENTER = 12'd1500;
    localparam logic [PULSE_W-1:0] PULSE_MAX    = 12'd2500;
    localparam int                 FRAME_US     = 20000;

    localparam logic signed [VAL_W-1:0] SPEED_LIMIT = 16'sd100;
    localparam logic signed [VAL_W-1:0] NUDGE_LIMIT = 16'sd400;
    localparam logic signed [VAL_W-1:0] ANGLE_MAX   = 16'sd180;
    localparam int                      SPEED_GAIN  = 5;

    // floor(2000 * c / 180) == (c * ANGLE_RECIP) >> ANGLE_SHIFT for c in 0..180.
    localparam int ANGLE_SHIFT = 16;
    localparam int ANGLE_RECIP =
        ((2500 - 500) * (2 ** ANGLE_SHIFT) + 180 - 1) / 180;
    localparam int ANGLE_PROD_W = 28;

    localparam logic [CHAN_W-1:0] CHAN_LEFT     = 4'd0;
    localparam logic [CHAN_W-1:0] CHAN_RIGHT    = 4'd1;
    localparam logic [CHAN_W-1:0] ARM_CHAN_BASE = 4'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_DRIVE = 3'd0,
        CMD_MOTOR = 3'd1,
        CMD_ANGLE = 3'd2,
        CMD_PULSE = 3'd3,
        CMD_NUDGE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        OP_PAIR,
        OP_SET,
        OP_NUDGE,
        OP_BAD
    } op_t;

    // One classified request as it waits in the queue.
    // PAIR: pa = left pulse, pb = right pulse. SET: pa = final pulse.
    // NUDGE: pa = signed step to add to the stored pulse.
    typedef struct packed {
        op_t                       op;
        logic [CHAN_W-1:0]         chan;
        logic signed [PULSE_W:0]   pa;
        logic [PULSE_W-1:0]        pb;
    } entry_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic [PULSE_W-1:0] pulse;
        logic               status;
        logic               last;
    } result_t;

    function automatic logic signed [7:0] clamp_speed(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] c;
        if (v < -SPEED_LIMIT) begin
            c = -SPEED_LIMIT;
        end else if (v > SPEED_LIMIT) begin
            c = SPEED_LIMIT;
        end else begin
            c = v;
        end
        return c[7:0];
    endfunction

    function automatic logic [PULSE_W-1:0] speed_pulse(input logic signed [7:0] s);
        logic signed [PULSE_W:0] t;
        t = 13'(signed'(PULSE_CENTER)) + 13'(s) * 13'(SPEED_GAIN);
        return t[PULSE_W-1:0];
    endfunction

endpackage

// ===== rtl/servo_pulse_command_engine_top.sv =====
// Servo pulse command engine.
// Requests arrive on the s_ valid/ready channel: a command, an arm index and two
// signed values. Drive and motor requests produce two results (left drive servo,
// then right drive servo with m_last set); arm requests produce one result, or an
// error result with m_status set when the arm index is out of range. Unknown
// commands produce nothing. Each result carries the new pulse width in
// microseconds and the PWM compare word, and the pulse is kept per servo for
// later nudges.
// The front stage classifies and clamps a request combinationally, registers
// it and places it in a four-entry queue; the back end takes one result per
// cycle from the queue head unless the output stalls, so a drive or motor
// request yields two results and an arm request one. A request passes the front
// register, the queue, s1 to s3 and the output register that drives m_valid;
// the duty word is formed by a three-stage multiply pipeline in the back end.
// When m_ready is low, results hold in the output register and the pipeline and
// queue fill before s_ready drops. Reset empties the pipeline, sets every stored
// pulse to 1500 us and sets mirror_right to 1. mirror_right sits at APB address 0
// and may be written only while no request is in flight.
module servo_pulse_command_engine_top #(
    parameter int NUM_SERVOS     = 7,
    parameter int NUM_ARM_SERVOS = 5,
    parameter int DUTY_BITS      = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [spce_pkg::CMD_W-1:0]         s_cmd,
    input  logic [spce_pkg::IDX_W-1:0]         s_joint_sel,
    input  logic signed [spce_pkg::VAL_W-1:0]  s_first_value,
    input  logic signed [spce_pkg::VAL_W-1:0]  s_second_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [spce_pkg::CHAN_OUT_W-1:0]    m_servo_channel,
    output logic [spce_pkg::PULSE_W-1:0]       m_pulse_width_us,
    output logic [spce_pkg::DUTY_W-1:0]        m_duty,
    output logic                               m_status,
    output logic                               m_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic               mirror_reg;
    logic               f_valid;
    logic               f_ready;
    spce_pkg::entry_t   f_entry;
    logic               q_valid;
    logic               q_pop;
    spce_pkg::entry_t   q_entry;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == spce_pkg::REG_MIRROR_RIGHT) ? {31'd0, mirror_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == spce_pkg::REG_MIRROR_RIGHT) begin
            mirror_reg <= pwdata[0];
        end
    end

    spce_front #(
        .NUM_SERVOS     (NUM_SERVOS),
        .NUM_ARM_SERVOS (NUM_ARM_SERVOS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_joint_sel    (s_joint_sel),
        .s_first_value  (s_first_value),
        .s_second_value (s_second_value),
        .mirror_right   (mirror_reg),
        .out_valid      (f_valid),
        .out_entry      (f_entry),
        .out_ready      (f_ready)
    );

    spce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_entry  (f_entry),
        .out_valid (q_valid),
        .out_entry (q_entry),
        .out_pop   (q_pop)
    );

    spce_back #(
        .NUM_SERVOS (NUM_SERVOS),
        .DUTY_BITS  (DUTY_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_entry          (q_entry),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_servo_channel  (m_servo_channel),
        .m_pulse_width_us (m_pulse_width_us),
        .m_duty           (m_duty),
        .m_status         (m_status),
        .m_last           (m_last)
    );

endmodule

// ===== rtl/spce_front.sv =====
module spce_front #(
    parameter int NUM_SERVOS     = 7,
    parameter int NUM_ARM_SERVOS = 5
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [spce_pkg::CMD_W-1:0]         s_cmd,
    input  logic [spce_pkg::IDX_W-1:0]         s_joint_sel,
    input  logic signed [spce_pkg::VAL_W-1:0]  s_first_value,
    input  logic signed [spce_pkg::VAL_W-1:0]  s_second_value,
    input  logic                               mirror_right,
    output logic                               out_valid,
    output spce_pkg::entry_t                   out_entry,
    input  logic                               out_ready
);

    logic                     valid_reg;
    spce_pkg::entry_t         entry_reg;
    spce_pkg::entry_t         entry_next;
    logic                     keep_next;

    logic signed [7:0]        x_spd;
    logic signed [7:0]        y_spd;
    logic signed [7:0]        left_spd;
    logic signed [7:0]        right_spd;
    logic signed [8:0]        mix_sum;
    logic signed [8:0]        mix_diff;
    logic                     bad_idx;
    logic [7:0]               angle;
    logic [spce_pkg::ANGLE_PROD_W-1:0] angle_prod;
    logic [spce_pkg::PULSE_W-1:0]      angle_pulse;
    logic [spce_pkg::PULSE_W-1:0]      direct_pulse;
    logic signed [spce_pkg::PULSE_W:0] nudge_amt;

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_entry = entry_reg;

    always_comb begin
        x_spd    = spce_pkg::clamp_speed(s_first_value);
        y_spd    = spce_pkg::clamp_speed(s_second_value);
        mix_sum  = 9'(y_spd) + 9'(x_spd);
        mix_diff = 9'(y_spd) - 9'(x_spd);

        if (spce_pkg::cmd_t'(s_cmd) == spce_pkg::CMD_DRIVE) begin
            left_spd  = spce_pkg::clamp_speed(16'(mix_sum));
            right_spd = spce_pkg::clamp_speed(16'(mix_diff));
        end else begin
            left_spd  = x_spd;
            right_spd = y_spd;
        end
        if (mirror_right) begin
            right_spd = -right_spd;
        end

        bad_idx = (int'(s_joint_sel) >= NUM_ARM_SERVOS) ||
                  (int'(s_joint_sel) + 2 >= NUM_SERVOS);

        if (s_first_value < 16'sd0) begin
            angle = 8'd0;
        end else if (s_first_value > spce_pkg::ANGLE_MAX) begin
            angle = 8'(spce_pkg::ANGLE_MAX);
        end else begin
            angle = s_first_value[7:0];
        end
        angle_prod  = spce_pkg::ANGLE_PROD_W'(angle) *
                      spce_pkg::ANGLE_PROD_W'(spce_pkg::ANGLE_RECIP);
        angle_pulse = spce_pkg::PULSE_MIN +
                      angle_prod[spce_pkg::ANGLE_SHIFT +: spce_pkg::PULSE_W];

        if (s_first_value < signed'(16'(spce_pkg::PULSE_MIN))) begin
            direct_pulse = spce_pkg::PULSE_MIN;
        end else if (s_first_value > signed'(16'(spce_pkg::PULSE_MAX))) begin
            direct_pulse = spce_pkg::PULSE_MAX;
        end else begin
            direct_pulse = s_first_value[spce_pkg::PULSE_W-1:0];
        end

        if (s_first_value < -spce_pkg::NUDGE_LIMIT) begin
            nudge_amt = 13'(-spce_pkg::NUDGE_LIMIT);
        end else if (s_first_value > spce_pkg::NUDGE_LIMIT) begin
            nudge_amt = 13'(spce_pkg::NUDGE_LIMIT);
        end else begin
            nudge_amt = s_first_value[spce_pkg::PULSE_W:0];
        end

        entry_next.op   = spce_pkg::OP_BAD;
        entry_next.chan = spce_pkg::CHAN_W'(s_joint_sel) + spce_pkg::ARM_CHAN_BASE;
        entry_next.pa   = '0;
        entry_next.pb   = '0;
        keep_next       = 1'b1;

        unique case (spce_pkg::cmd_t'(s_cmd))
            spce_pkg::CMD_DRIVE, spce_pkg::CMD_MOTOR: begin
                entry_next.op   = spce_pkg::OP_PAIR;
                entry_next.chan = spce_pkg::CHAN_LEFT;
                entry_next.pa   = signed'({1'b0, spce_pkg::speed_pulse(left_spd)});
                entry_next.pb   = spce_pkg::speed_pulse(right_spd);
            end
            spce_pkg::CMD_ANGLE: begin
                entry_next.op = spce_pkg::OP_SET;
                entry_next.pa = signed'({1'b0, angle_pulse});
            end
            spce_pkg::CMD_PULSE: begin
                entry_next.op = spce_pkg::OP_SET;
                entry_next.pa = signed'({1'b0, direct_pulse});
            end
            spce_pkg::CMD_NUDGE: begin
                entry_next.op = spce_pkg::OP_NUDGE;
                entry_next.pa = nudge_amt;
            end
            default: begin
                keep_next = 1'b0;
            end
        endcase

        // Arm requests with an index past the arm servos report an error only.
        if (entry_next.op != spce_pkg::OP_PAIR && bad_idx) begin
            entry_next.op   = spce_pkg::OP_BAD;
            entry_next.chan = '0;
            entry_next.pa   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid && keep_next;
        end
        if (s_ready && s_valid) begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== rtl/spce_queue.sv =====
module spce_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  spce_pkg::entry_t  in_entry,
    output logic              out_valid,
    output spce_pkg::entry_t  out_entry,
    input  logic              out_pop
);

    spce_pkg::entry_t               mem_reg [spce_pkg::QUEUE_DEPTH];
    logic [spce_pkg::QPTR_W-1:0]    wptr_reg;
    logic [spce_pkg::QPTR_W-1:0]    rptr_reg;
    logic [spce_pkg::QPTR_W:0]      count_reg;
    logic                           push;
    logic                           pop;

    assign in_ready  = count_reg != (spce_pkg::QPTR_W + 1)'(spce_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_entry = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wptr_reg] <= in_entry;
        end
    end

endmodule

// ===== rtl/spce_back.sv =====
module spce_back #(
    parameter int NUM_SERVOS = 7,
    parameter int DUTY_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  spce_pkg::entry_t                    q_entry,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [spce_pkg::CHAN_OUT_W-1:0]     m_servo_channel,
    output logic [spce_pkg::PULSE_W-1:0]        m_pulse_width_us,
    output logic [spce_pkg::DUTY_W-1:0]         m_duty,
    output logic                                m_status,
    output logic                                m_last
);

    localparam int SIDX_W = $clog2(NUM_SERVOS);
    localparam int PROD_W = spce_pkg::PULSE_W + DUTY_BITS;
    localparam int Q_W    = PROD_W - 14;
    localparam logic [DUTY_BITS-1:0] DUTY_SCALE = '1;
    localparam logic [63:0] RECIP_FULL = (64'd1 << PROD_W) / 64'd20000;
    localparam logic [Q_W-1:0] RECIP = RECIP_FULL[Q_W-1:0];

    logic [spce_pkg::PULSE_W-1:0] store_reg [NUM_SERVOS];
    logic                         phase_reg;

    logic                         s1_valid_reg;
    spce_pkg::result_t            s1_reg;
    logic                         s2_valid_reg;
    spce_pkg::result_t            s2_reg;
    logic [PROD_W-1:0]            s2_prod_reg;
    logic                         s3_valid_reg;
    spce_pkg::result_t            s3_reg;
    logic [PROD_W-1:0]            s3_prod_reg;
    logic [Q_W-1:0]               s3_qest_reg;
    logic                         out_valid_reg;
    spce_pkg::result_t            out_reg;
    logic [spce_pkg::DUTY_W-1:0]  out_duty_reg;

    logic                         out_rdy;
    logic                         s3_rdy;
    logic                         s2_rdy;
    logic                         s1_rdy;
    logic                         s0_fire;
    spce_pkg::result_t            s0_res;
    logic [spce_pkg::PULSE_W-1:0] store_rd;
    logic signed [spce_pkg::PULSE_W+1:0] nudge_sum;
    logic [PROD_W+Q_W-1:0]        recip_prod;
    logic [PROD_W-1:0]            rem;
    logic [Q_W-1:0]               quot;
    logic [Q_W+spce_pkg::DUTY_W-1:0] quot_ext;

    assign out_rdy = !out_valid_reg || m_ready;
    assign s3_rdy  = !s3_valid_reg || out_rdy;
    assign s2_rdy  = !s2_valid_reg || s3_rdy;
    assign s1_rdy  = !s1_valid_reg || s2_rdy;
    assign s0_fire = q_valid && s1_rdy;
    assign q_pop   = s0_fire && (q_entry.op != spce_pkg::OP_PAIR || phase_reg);

    assign store_rd  = store_reg[q_entry.chan[SIDX_W-1:0]];
    assign nudge_sum = 14'(signed'({1'b0, store_rd})) + 14'(q_entry.pa);

    always_comb begin
        s0_res.chan   = q_entry.chan;
        s0_res.pulse  = q_entry.pa[spce_pkg::PULSE_W-1:0];
        s0_res.status = 1'b0;
        s0_res.last   = 1'b1;
        unique case (q_entry.op)
            spce_pkg::OP_PAIR: begin
                s0_res.chan  = phase_reg ? spce_pkg::CHAN_RIGHT : spce_pkg::CHAN_LEFT;
                s0_res.pulse = phase_reg ? q_entry.pb : q_entry.pa[spce_pkg::PULSE_W-1:0];
                s0_res.last  = phase_reg;
            end
            spce_pkg::OP_SET: begin
            end
            spce_pkg::OP_NUDGE: begin
                if (nudge_sum < 14'(spce_pkg::PULSE_MIN)) begin
                    s0_res.pulse = spce_pkg::PULSE_MIN;
                end else if (nudge_sum > 14'(spce_pkg::PULSE_MAX)) begin
                    s0_res.pulse = spce_pkg::PULSE_MAX;
                end else begin
                    s0_res.pulse = nudge_sum[spce_pkg::PULSE_W-1:0];
                end
            end
            spce_pkg::OP_BAD: begin
                s0_res.chan   = '0;
                s0_res.pulse  = '0;
                s0_res.status = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // The estimate from the reciprocal is low by at most one; one compare fixes it.
    always_comb begin
        recip_prod = (PROD_W + Q_W)'(s2_prod_reg) * (PROD_W + Q_W)'(RECIP);
        rem        = s3_prod_reg - PROD_W'(s3_qest_reg) * PROD_W'(spce_pkg::FRAME_US);
        quot       = s3_qest_reg + Q_W'(rem >= PROD_W'(spce_pkg::FRAME_US));
        quot_ext   = (Q_W + spce_pkg::DUTY_W)'(quot);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SERVOS; i++) begin
                store_reg[i] <= spce_pkg::PULSE_CENTER;
            end
            phase_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s0_fire && q_entry.op != spce_pkg::OP_BAD) begin
                store_reg[s0_res.chan[SIDX_W-1:0]] <= s0_res.pulse;
            end
            if (s0_fire && q_entry.op == spce_pkg::OP_PAIR) begin
                phase_reg <= !phase_reg;
            end
            if (s1_rdy) begin
                s1_valid_reg <= s0_fire;
            end
            if (s2_rdy) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_rdy) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_rdy) begin
                out_valid_reg <= s3_valid_reg;
            end
        end
        if (s1_rdy) begin
            s1_reg <= s0_res;
        end
        if (s2_rdy) begin
            s2_reg      <= s1_reg;
            s2_prod_reg <= PROD_W'(s1_reg.pulse) * PROD_W'(DUTY_SCALE);
        end
        if (s3_rdy) begin
            s3_reg      <= s2_reg;
            s3_prod_reg <= s2_prod_reg;
            s3_qest_reg <= recip_prod[PROD_W +: Q_W];
        end
        if (out_rdy) begin
            out_reg      <= s3_reg;
            out_duty_reg <= quot_ext[spce_pkg::DUTY_W-1:0];
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_servo_channel  = out_reg.chan[spce_pkg::CHAN_OUT_W-1:0];
    assign m_pulse_width_us = out_reg.pulse;
    assign m_duty           = out_duty_reg;
    assign m_status         = out_reg.status;
    assign m_last           = out_reg.last;

    a_phase_on_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (q_valid && q_entry.op == spce_pkg::OP_PAIR))
        else $error("second half of a pair pending without a pair at the queue head");

    a_bad_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status) |->
            (out_reg.last && out_reg.pulse == '0 && out_duty_reg == '0))
        else $error("error result carries a pulse or duty");

    a_pulse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.status) |->
            (out_reg.pulse >= spce_pkg::PULSE_MIN && out_reg.pulse <= spce_pkg::PULSE_MAX))
        else $error("written pulse outside 500..2500");

    a_first_is_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.last) |->
            (out_reg.chan == spce_pkg::CHAN_LEFT && !out_reg.status))
        else $error("non-final result is not the left drive servo");

endmodule
